>>> design/ggiw_pkg.sv
package ggiw_pkg;

  localparam int CELLS_ACROSS_DEF = 16;
  localparam int CELLS_DOWN_DEF   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH  = 2'd2;

  localparam logic [8:0]  CELL_SIZE_RST  = 9'd8;
  localparam logic [12:0] ROW_LENGTH_RST = 13'd128;

  // one cell column's ink record
  typedef struct packed {
    logic       seen;
    logic [7:0] left;
    logic [7:0] right;
  } ink_rec_t;

  // broadcast control for the cell chain
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       ink;
    logic [7:0] x;
  } cell_ctl_t;

  // raster position status
  typedef struct packed {
    logic [7:0] x;
    logic       live;
    logic       band_live;
    logic       band_end;
  } pos_t;

  function automatic logic [8:0] clamp_cell(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    return r;
  endfunction

  function automatic logic [12:0] clamp_row(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v == 13'd0) r = 13'd1;
    else if (v > 13'd4096) r = 13'd4096;
    return r;
  endfunction

endpackage

>>> design/ggiw_cell.sv
module ggiw_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ggiw_pkg::cell_ctl_t ctl,
  input  logic                hit,
  input  ggiw_pkg::ink_rec_t  nb_in,
  output ggiw_pkg::ink_rec_t  rec
);

  ggiw_pkg::ink_rec_t rec_r, rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.clear) begin
      rec_nxt = '0;
    end else if (ctl.shift) begin
      rec_nxt = nb_in;
    end else if (ctl.ink && hit) begin
      if (!rec_r.seen) begin
        rec_nxt.seen  = 1'b1;
        rec_nxt.left  = ctl.x;
        rec_nxt.right = ctl.x;
      end else begin
        if (ctl.x < rec_r.left)  rec_nxt.left  = ctl.x;
        if (ctl.x > rec_r.right) rec_nxt.right = ctl.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.seen <= 1'b0;
    end else begin
      rec_r.seen <= rec_nxt.seen;
    end
    rec_r.left  <= rec_nxt.left;
    rec_r.right <= rec_nxt.right;
  end

  assign rec = rec_r;

endmodule

>>> design/ggiw_pos.sv
module ggiw_pos #(
  parameter int CELLS_ACROSS = ggiw_pkg::CELLS_ACROSS_DEF,
  parameter int CELLS_DOWN   = ggiw_pkg::CELLS_DOWN_DEF,
  localparam int CCW = $clog2(CELLS_ACROSS + 1),
  localparam int BW  = $clog2(CELLS_DOWN + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [8:0]       cw,
  input  logic [8:0]       ch,
  input  logic [12:0]      rl,
  output ggiw_pkg::pos_t   pos,
  output logic [CCW-1:0]   cell_col,
  output logic [BW-1:0]    band
);

  logic [11:0]    pc_r, pc_nxt;
  logic [7:0]     prc_r, prc_nxt;
  logic [7:0]     cic_r, cic_nxt;
  logic [CCW-1:0] col_r, col_nxt;
  logic [BW-1:0]  band_r, band_nxt;

  logic [8:0]  cic_inc;
  logic [8:0]  prc_inc;
  logic [12:0] pc_inc;
  logic        col_live;
  logic        band_live;
  logic        row_end;

  assign cic_inc   = {1'b0, cic_r} + 9'd1;
  assign prc_inc   = {1'b0, prc_r} + 9'd1;
  assign pc_inc    = {1'b0, pc_r} + 13'd1;
  assign col_live  = col_r < CCW'(CELLS_ACROSS);
  assign band_live = band_r < BW'(CELLS_DOWN);
  assign row_end   = pc_inc >= rl;

  always_comb begin
    pc_nxt   = pc_r;
    prc_nxt  = prc_r;
    cic_nxt  = cic_r;
    col_nxt  = col_r;
    band_nxt = band_r;
    if (step) begin
      if (cic_inc >= cw) begin
        cic_nxt = 8'd0;
        if (col_live) col_nxt = col_r + CCW'(1);
      end else begin
        cic_nxt = cic_inc[7:0];
      end
      if (row_end) begin
        pc_nxt  = 12'd0;
        cic_nxt = 8'd0;
        col_nxt = '0;
        if (prc_inc >= ch) begin
          prc_nxt = 8'd0;
          if (band_live) band_nxt = band_r + BW'(1);
        end else begin
          prc_nxt = prc_inc[7:0];
        end
      end else begin
        pc_nxt = pc_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      prc_r  <= '0;
      cic_r  <= '0;
      col_r  <= '0;
      band_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      prc_r  <= prc_nxt;
      cic_r  <= cic_nxt;
      col_r  <= col_nxt;
      band_r <= band_nxt;
    end
  end

  assign pos.x         = cic_r;
  assign pos.live      = col_live && band_live;
  assign pos.band_live = band_live;
  assign pos.band_end  = row_end && (prc_inc >= ch);
  assign cell_col      = col_r;
  assign band          = band_r;

endmodule

>>> design/glyph_grid_ink_width_top.sv
// Per-cell horizontal ink width of a glyph atlas. Pixels (first channel only) are taken one per
// cycle in raster order; a row of CELLS_ACROSS cells, one per cell column, tracks whether any
// nonzero sample fell in that column of the current band and its least and greatest x. After the
// last pixel of a band the input stalls while the records shift down the cell chain and leave
// from cell 0, one result per cycle with out_ready high, in glyph order; the shift leaves the
// chain cleared for the next band. Once CELLS_DOWN bands are done, further pixels are taken and
// ignored. The user must write configuration only while no transfer is in flight; the block
// itself does not enforce this.
module glyph_grid_ink_width_top #(
  parameter int CELLS_ACROSS = ggiw_pkg::CELLS_ACROSS_DEF,
  parameter int CELLS_DOWN   = ggiw_pkg::CELLS_DOWN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_glyph_code,
  output logic [8:0]                      out_ink_width,
  output logic                            out_band_last,
  input  logic                            cfg_we,
  input  logic [ggiw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ggiw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CCW = $clog2(CELLS_ACROSS + 1);
  localparam int BW  = $clog2(CELLS_DOWN + 1);
  localparam int DW  = (CELLS_ACROSS > 1) ? $clog2(CELLS_ACROSS) : 1;

  logic [8:0]  cw_r, ch_r;
  logic [12:0] rl_r;

  logic           drain_r, drain_nxt;
  logic [DW-1:0]  dcnt_r, dcnt_nxt;
  logic [7:0]     glyph_r, glyph_nxt;

  logic           step;
  logic           out_xfer;
  logic           last;
  ggiw_pkg::pos_t pos;
  logic [CCW-1:0] cell_col;
  logic [BW-1:0]  band;

  ggiw_pkg::cell_ctl_t ctl;
  ggiw_pkg::ink_rec_t  chain [CELLS_ACROSS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= ggiw_pkg::CELL_SIZE_RST;
      ch_r <= ggiw_pkg::CELL_SIZE_RST;
      rl_r <= ggiw_pkg::ROW_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ggiw_pkg::CFG_CELL_WIDTH:  cw_r <= cfg_data[8:0];
        ggiw_pkg::CFG_CELL_HEIGHT: ch_r <= cfg_data[8:0];
        ggiw_pkg::CFG_ROW_LENGTH:  rl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !drain_r;
  assign step     = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign last     = dcnt_r == DW'(CELLS_ACROSS - 1);

  ggiw_pos #(
    .CELLS_ACROSS(CELLS_ACROSS),
    .CELLS_DOWN  (CELLS_DOWN)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cw      (ggiw_pkg::clamp_cell(cw_r)),
    .ch      (ggiw_pkg::clamp_cell(ch_r)),
    .rl      (ggiw_pkg::clamp_row(rl_r)),
    .pos     (pos),
    .cell_col(cell_col),
    .band    (band)
  );

  assign ctl.shift = out_xfer;
  assign ctl.clear = step && pos.band_end && !pos.band_live;
  assign ctl.ink   = step && pos.live && (in_sample != 8'd0);
  assign ctl.x     = pos.x;

  // records move toward cell 0; the far end fills with empty records
  assign chain[CELLS_ACROSS] = '0;

  for (genvar i = 0; i < CELLS_ACROSS; i++) begin : g_cell
    ggiw_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .hit  (cell_col == CCW'(i)),
      .nb_in(chain[i+1]),
      .rec  (chain[i])
    );
  end

  always_comb begin
    drain_nxt = drain_r;
    dcnt_nxt  = dcnt_r;
    glyph_nxt = glyph_r;
    if (drain_r) begin
      if (out_xfer) begin
        glyph_nxt = glyph_r + 8'd1;
        if (last) begin
          drain_nxt = 1'b0;
          dcnt_nxt  = '0;
        end else begin
          dcnt_nxt = dcnt_r + DW'(1);
        end
      end
    end else if (step && pos.band_end && pos.band_live) begin
      drain_nxt = 1'b1;
      dcnt_nxt  = '0;
      glyph_nxt = 8'(int'(band) * CELLS_ACROSS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      drain_r <= drain_nxt;
      dcnt_r  <= dcnt_nxt;
    end
    glyph_r <= glyph_nxt;
  end

  assign out_valid      = drain_r;
  assign out_glyph_code = glyph_r;
  assign out_ink_width  = chain[0].seen ?
                          ({1'b0, chain[0].right} - {1'b0, chain[0].left} + 9'd1) : 9'd0;
  assign out_band_last  = last;

endmodule

>>> design/ggiw_checker.sv
module ggiw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [7:0]                      in_sample,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [7:0]                      out_glyph_code,
  input logic [8:0]                      out_ink_width,
  input logic                            out_band_last
);

  // pixel offer held until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample))
    else $error("pixel offer dropped or changed while stalled");

  // results held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_glyph_code)
      && $stable(out_ink_width) && $stable(out_band_last))
    else $error("result changed while stalled");

  // input is stalled for the whole band drain
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during band drain");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_band_last |=> !out_valid)
    else $error("results continue past band end");

  a_drain_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_band_last |=> out_valid
      && out_glyph_code == $past(out_glyph_code) + 8'd1)
    else $error("band drain broke off or skipped a glyph");

endmodule

bind glyph_grid_ink_width_top ggiw_checker u_ggiw_checker (.*);

>>> tb/glyph_grid_ink_width_top_tb.sv
module glyph_grid_ink_width_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACROSS = ggiw_pkg::CELLS_ACROSS_DEF;
  localparam int DOWN   = ggiw_pkg::CELLS_DOWN_DEF;
  localparam int SETTLE_CYCLES = ggiw_pkg::CELLS_ACROSS_DEF + 8;

  typedef struct packed {
    logic [7:0] glyph_code;
    logic [8:0] ink_width;
    logic       band_last;
  } ink_result_t;

  typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_QUARTER, DRAIN_MOST} drain_pace_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_sample = 8'd0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [7:0]                      out_glyph_code;
  logic [8:0]                      out_ink_width;
  logic                            out_band_last;
  logic                            cfg_we = 1'b0;
  logic [ggiw_pkg::CFG_IDX_W-1:0]  cfg_index = ggiw_pkg::CFG_CELL_WIDTH;
  logic [ggiw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  glyph_grid_ink_width_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_glyph_code(out_glyph_code),
    .out_ink_width (out_ink_width),
    .out_band_last (out_band_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ink tracker: registers, raster position and per-column ink records
  logic [8:0]  cell_w_reg = ggiw_pkg::CELL_SIZE_RST;
  logic [8:0]  cell_h_reg = ggiw_pkg::CELL_SIZE_RST;
  logic [12:0] row_len_reg = ggiw_pkg::ROW_LENGTH_RST;
  logic [11:0] pix_col = '0;
  logic [7:0]  row_in_cell = '0;
  logic [4:0]  band_idx = '0;
  logic [7:0]  x_in_cell = '0;
  logic [4:0]  cell_col = '0;
  logic        ink_seen_q [ACROSS];
  logic [7:0]  ink_left [ACROSS];
  logic [7:0]  ink_right [ACROSS];
  int          band_ends = 0;

  ink_result_t expected_widths [$];
  int          mismatch_count = 0;

  int          burst_left = 4;
  bit          hold_request = 0;
  int          hold_left = 0;
  drain_pace_t drain_pace = DRAIN_FULL;
  int          pace_left = 0;

  initial begin
    for (int c = 0; c < ACROSS; c++) begin
      ink_seen_q[c] = 1'b0;
      ink_left[c] = '0;
      ink_right[c] = '0;
    end
  end

  function automatic int eff_size(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic track_pixel(input logic [7:0] s);
    int cw, ch, rl;
    ink_result_t r;
    cw = eff_size(int'(cell_w_reg), 256);
    ch = eff_size(int'(cell_h_reg), 256);
    rl = eff_size(int'(row_len_reg), 4096);
    if (band_idx < DOWN && cell_col < ACROSS && s != 8'd0) begin
      if (!ink_seen_q[cell_col]) begin
        ink_seen_q[cell_col] = 1'b1;
        ink_left[cell_col] = x_in_cell;
        ink_right[cell_col] = x_in_cell;
      end else begin
        if (x_in_cell < ink_left[cell_col]) ink_left[cell_col] = x_in_cell;
        if (x_in_cell > ink_right[cell_col]) ink_right[cell_col] = x_in_cell;
      end
    end
    if (int'(x_in_cell) + 1 >= cw) begin
      x_in_cell = '0;
      if (cell_col < ACROSS) cell_col = cell_col + 5'd1;
    end else begin
      x_in_cell = x_in_cell + 8'd1;
    end
    if (int'(pix_col) + 1 >= rl) begin
      pix_col = '0;
      x_in_cell = '0;
      cell_col = '0;
      if (int'(row_in_cell) + 1 >= ch) begin
        row_in_cell = '0;
        band_ends++;
        if (band_idx < DOWN) begin
          for (int c = 0; c < ACROSS; c++) begin
            r.glyph_code = 8'(int'(band_idx) * ACROSS + c);
            r.ink_width = ink_seen_q[c] ? ({1'b0, ink_right[c]} - {1'b0, ink_left[c]} + 9'd1)
                                        : 9'd0;
            r.band_last = (c == ACROSS - 1);
            expected_widths.push_back(r);
          end
          band_idx = band_idx + 5'd1;
        end
        for (int c = 0; c < ACROSS; c++) begin
          ink_seen_q[c] = 1'b0;
          ink_left[c] = '0;
          ink_right[c] = '0;
        end
      end else begin
        row_in_cell = row_in_cell + 8'd1;
      end
    end else begin
      pix_col = pix_col + 12'd1;
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : result_check
    ink_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_widths.size() == 0) begin
        report_mismatch($sformatf("unexpected result, glyph %0d width %0d",
                                  out_glyph_code, out_ink_width));
      end else begin
        want = expected_widths.pop_front();
        if (out_glyph_code !== want.glyph_code)
          report_mismatch($sformatf("glyph_code %0d, want %0d", out_glyph_code,
                                    want.glyph_code));
        if (out_ink_width !== want.ink_width)
          report_mismatch($sformatf("glyph %0d ink_width %0d, want %0d", want.glyph_code,
                                    out_ink_width, want.ink_width));
        if (out_band_last !== want.band_last)
          report_mismatch($sformatf("glyph %0d band_last %0b, want %0b", want.glyph_code,
                                    out_band_last, want.band_last));
      end
    end
  end

  // receiver pacing, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = 90;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (pace_left == 0) begin
        drain_pace = drain_pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(20, 80);
      end
      pace_left--;
      case (drain_pace)
        DRAIN_FULL: out_ready <= 1'b1;
        DRAIN_HALF: out_ready <= 1'($urandom_range(0, 1));
        DRAIN_QUARTER: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_pixel(input logic [7:0] s);
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_pixel(s);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // sender stops, every transfer drains, then the block gets time to go quiet
  task automatic wait_block_idle();
    if (burst_left > 0) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 8);
    end
    while (expected_widths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [12:0] cw, input logic [12:0] ch,
                                input logic [12:0] rl);
    cfg_we <= 1'b1;
    cfg_index <= ggiw_pkg::CFG_CELL_WIDTH;
    cfg_data <= cw;
    @(posedge clk);
    cell_w_reg = cw[8:0];
    cfg_index <= ggiw_pkg::CFG_CELL_HEIGHT;
    cfg_data <= ch;
    @(posedge clk);
    cell_h_reg = ch[8:0];
    cfg_index <= ggiw_pkg::CFG_ROW_LENGTH;
    cfg_data <= rl;
    @(posedge clk);
    row_len_reg = rl;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sample(input int density);
    if ($urandom_range(0, 99) < density) return 8'($urandom_range(1, 255));
    return 8'd0;
  endfunction

  task automatic set_random_geometry();
    logic [12:0] cw, ch, rl;
    cw = ($urandom_range(0, 5) == 0) ? 13'd0 : 13'($urandom_range(1, 3));
    ch = ($urandom_range(0, 5) == 0) ? 13'd0 : (($urandom_range(0, 7) == 0) ? 13'd2 : 13'd1);
    case ($urandom_range(0, 5))
      0: rl = 13'(16 * ((cw == 13'd0) ? 1 : int'(cw)));
      1: rl = 13'($urandom_range(0, 15));
      default: rl = 13'($urandom_range(12, 20));
    endcase
    write_geometry(cw, ch, rl);
  endtask

  // zero cell sizes act as one pixel, so every pixel is a cell of its own
  task automatic test_unit_cells_sample_extremes();
    logic [7:0] pattern [16] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 8'h55,
                                 8'hAA, 8'h00, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
    write_geometry(13'd0, 13'd0, 13'd16);
    foreach (pattern[i]) send_pixel(pattern[i]);
    wait_block_idle();
  endtask

  // oversized, extreme and then shrunken geometry while a row is under way
  task automatic test_register_change_mid_row();
    write_geometry(13'd511, 13'd511, 13'd8191);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h80);
    wait_block_idle();
    write_geometry(13'd256, 13'd256, 13'd4096);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h7F);
    wait_block_idle();
    // the in-cell x counter now sits beyond the new cell width and wraps on the next pixel
    write_geometry(13'd2, 13'd1, 13'd10);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h40);
    wait_block_idle();
  endtask

  task automatic test_random_bands();
    int  iter, start_ends, density, n;
    bit  need_cfg, pressure;
    iter = 0;
    need_cfg = 1;
    while (band_idx < DOWN) begin
      pressure = (iter == 3 || iter == 4);
      if (!pressure && (need_cfg || $urandom_range(0, 1) == 1)) begin
        wait_block_idle();
        set_random_geometry();
        need_cfg = 0;
      end
      if (iter == 3) hold_request = 1;
      case ($urandom_range(0, 4))
        0: density = 0;
        1: density = 100;
        2: density = 15;
        default: density = $urandom_range(20, 80);
      endcase
      if (!pressure && $urandom_range(0, 4) == 0) begin
        // partial band; a new geometry is written at the next iteration that is not under pressure
        n = $urandom_range(1, 12);
        repeat (n) send_pixel(pick_sample(density));
        need_cfg = 1;
      end else begin
        start_ends = band_ends;
        while (band_ends == start_ends) send_pixel(pick_sample(density));
      end
      iter++;
    end
    wait_block_idle();
  endtask

  // every band of the grid is done: more pixels, including band ends, give nothing
  task automatic test_past_last_band();
    write_geometry(13'd1, 13'd2, 13'd0);
    repeat (12) send_pixel(8'($urandom_range(0, 255)));
    wait_block_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unit_cells_sample_extremes();
    test_register_change_mid_row();
    test_random_bands();
    test_past_last_band();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_widths.size() == 0) begin
      $display("glyph_grid_ink_width_top regression: pass");
    end else begin
      $display("glyph_grid_ink_width_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("glyph_grid_ink_width_top regression: fail");
    $finish;
  end

endmodule
